@@ hw/rtl/yuvrgb_pkg.sv @@
package yuvrgb_pkg;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 12;
    localparam int SAMPLE_W     = 8;
    localparam int CHROMA_W     = 2 * SAMPLE_W;
    localparam int ROW_W        = 11;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int WIDTH_RESET  = 720;
    localparam int HEIGHT_RESET = 540;
    localparam int CHROMA_BIAS  = 128;

    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [SAMPLE_W-1:0] COMPONENT_MAX = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CHROMA_NEW  = 2'd0,
        CHROMA_HOLD = 2'd1,
        CHROMA_LINE = 2'd2
    } chroma_src_t;

endpackage

@@ hw/rtl/yuv420_to_rgb32_converter.sv @@
// Channel  | Direction | Handshake                 | Payload
// pixel    | in        | pixel_valid / pixel_stall | y_sample, u_sample, v_sample,
//          |           |                           | start_of_frame
// rgb      | out       | rgb_valid / rgb_stall     | red, green, blue, alpha, end_of_line,
//          |           |                           | end_of_frame
// cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One pixel is accepted per clock while pixel_stall is low.
// Its result passes through the input register (beside the line store read port) and then the result register.
// Reset clears the counters, the valid flags and the held chroma pair.
// The line store is not cleared.
// A stall on the result channel holds both stages, and the pixel channel stalls only when both are full.
module yuv420_to_rgb32_converter #(
    parameter int MAX_LINE_WIDTH     = 2048,
    parameter int COEF_FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]       y_sample,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]       u_sample,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]       v_sample,
    input  logic                                  start_of_frame,
    output logic                                  rgb_valid,
    input  logic                                  rgb_stall,
    output logic [yuvrgb_pkg::SAMPLE_W-1:0]       red,
    output logic [yuvrgb_pkg::SAMPLE_W-1:0]       green,
    output logic [yuvrgb_pkg::SAMPLE_W-1:0]       blue,
    output logic [yuvrgb_pkg::SAMPLE_W-1:0]       alpha,
    output logic                                  end_of_line,
    output logic                                  end_of_frame,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [yuvrgb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import yuvrgb_pkg::*;

    localparam int CW    = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 2;
    localparam int AW    = CW - 1;
    localparam int DEPTH = (MAX_LINE_WIDTH + 1) / 2;
    localparam int F     = COEF_FRACTION_BITS;
    localparam int SW    = F + 11;

    localparam int WIDTH_RST = (WIDTH_RESET > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : WIDTH_RESET;

    localparam longint ONE_F   = longint'(1) << F;
    localparam longint COEF_RV = (1402 * ONE_F + 500) / 1000;
    localparam longint COEF_GU = (34414 * ONE_F + 50000) / 100000;
    localparam longint COEF_GV = (71414 * ONE_F + 50000) / 100000;
    localparam longint COEF_BU = (1772 * ONE_F + 500) / 1000;

    localparam logic signed [SW-1:0] K_RV = SW'(COEF_RV);
    localparam logic signed [SW-1:0] K_GU = SW'(COEF_GU);
    localparam logic signed [SW-1:0] K_GV = SW'(COEF_GV);
    localparam logic signed [SW-1:0] K_BU = SW'(COEF_BU);

    logic [CW-1:0]    width_last_reg;
    logic [ROW_W-1:0] height_last_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CW-1:0]    col_start, col_cur;
    logic [ROW_W-1:0] row_start, row_cur;
    logic             col_wrap;
    logic             pix_eol, pix_eof;
    logic             accept;
    logic             s1_free;
    logic             out_load;
    logic             line_write;
    logic [AW-1:0]    line_index;
    chroma_src_t      pix_src;

    logic [CHROMA_W-1:0] chroma_line_mem [DEPTH];
    logic [CHROMA_W-1:0] line_rd_reg;

    logic                s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0] s1_y_reg;
    logic [CHROMA_W-1:0] s1_uv_reg;
    chroma_src_t         s1_src_reg;
    logic                s1_eol_reg;
    logic                s1_eof_reg;
    logic [CHROMA_W-1:0] chroma_hold_reg;
    logic [CHROMA_W-1:0] chroma_cur;

    logic signed [SW-1:0] cb_ext, cr_ext, y_base;
    logic signed [SW-1:0] red_acc, green_acc, blue_acc;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] red_reg, green_reg, blue_reg;
    logic                eol_reg, eof_reg;

    function automatic logic [SAMPLE_W-1:0] clamp_component(input logic signed [SW-1:0] acc);
        logic [SAMPLE_W-1:0] res;
        if (acc[SW-1])
            res = '0;
        else if (|acc[SW-2:F+SAMPLE_W])
            res = COMPONENT_MAX;
        else
            res = acc[F+SAMPLE_W-1:F];
        return res;
    endfunction

    // Register file: effective values minus one are kept, so the counters compare directly.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= CW'(WIDTH_RST - 1);
            height_last_reg <= ROW_W'(HEIGHT_RESET - 1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_last_reg <= '0;
                    else if (int'(cfg_data) > MAX_LINE_WIDTH)
                        width_last_reg <= CW'(MAX_LINE_WIDTH - 1);
                    else
                        width_last_reg <= CW'(cfg_data - 12'd1);
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_last_reg <= '0;
                    else if (int'(cfg_data) > HEIGHT_LIMIT)
                        height_last_reg <= ROW_W'(HEIGHT_LIMIT - 1);
                    else
                        height_last_reg <= ROW_W'(cfg_data - 12'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Handshake of the two stages.
    assign out_load    = s1_valid_reg && (!out_valid_reg || !rgb_stall);
    assign s1_free     = !s1_valid_reg || !out_valid_reg || !rgb_stall;
    assign pixel_stall = !s1_free;
    assign accept      = pixel_valid && s1_free;

    // Raster position of the pixel being accepted.
    always_comb
    begin
        col_start = start_of_frame ? '0 : col_reg;
        row_start = start_of_frame ? '0 : row_reg;
        col_wrap  = col_start > width_last_reg;
        col_cur   = col_wrap ? '0 : col_start;
        if (col_wrap)
            row_cur = (row_start >= height_last_reg) ? '0 : row_start + 1'b1;
        else
            row_cur = (row_start > height_last_reg) ? '0 : row_start;

        pix_eol = col_cur == width_last_reg;
        pix_eof = pix_eol && (row_cur == height_last_reg);

        if (pix_eol)
        begin
            col_next = '0;
            row_next = pix_eof ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end

        line_index = col_cur[CW-1:1];
        if (row_cur[0])
            pix_src = CHROMA_LINE;
        else if (col_cur[0])
            pix_src = CHROMA_HOLD;
        else
            pix_src = CHROMA_NEW;
        line_write = pix_src == CHROMA_NEW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store of chroma pairs from the last even row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (line_write)
                chroma_line_mem[line_index] <= {u_sample, v_sample};
            line_rd_reg <= chroma_line_mem[line_index];
        end
    end

    // Input register.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_y_reg   <= y_sample;
            s1_uv_reg  <= {u_sample, v_sample};
            s1_src_reg <= pix_src;
            s1_eol_reg <= pix_eol;
            s1_eof_reg <= pix_eof;
        end
    end

    // Conversion.
    always_comb
    begin
        case (s1_src_reg)
            CHROMA_NEW:  chroma_cur = s1_uv_reg;
            CHROMA_HOLD: chroma_cur = chroma_hold_reg;
            CHROMA_LINE: chroma_cur = line_rd_reg;
            default:     chroma_cur = chroma_hold_reg;
        endcase

        cb_ext = SW'(chroma_cur[CHROMA_W-1:SAMPLE_W]) - SW'(CHROMA_BIAS);
        cr_ext = SW'(chroma_cur[SAMPLE_W-1:0]) - SW'(CHROMA_BIAS);
        y_base = SW'(s1_y_reg) <<< F;

        red_acc   = y_base + K_RV * cr_ext;
        green_acc = y_base - K_GU * cb_ext - K_GV * cr_ext;
        blue_acc  = y_base + K_BU * cb_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chroma_hold_reg <= '0;
        else if (out_load)
            chroma_hold_reg <= chroma_cur;
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !rgb_stall)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= clamp_component(red_acc);
            green_reg <= clamp_component(green_acc);
            blue_reg  <= clamp_component(blue_acc);
            eol_reg   <= s1_eol_reg;
            eof_reg   <= s1_eof_reg;
        end
    end

    assign rgb_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = ALPHA_OPAQUE;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

@@ hw/rtl/yuvrgb_checker.sv @@
module yuvrgb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               pixel_valid,
    input logic                               pixel_stall,
    input logic                               rgb_valid,
    input logic                               rgb_stall,
    input logic [yuvrgb_pkg::SAMPLE_W-1:0]    red,
    input logic [yuvrgb_pkg::SAMPLE_W-1:0]    green,
    input logic [yuvrgb_pkg::SAMPLE_W-1:0]    blue,
    input logic [yuvrgb_pkg::SAMPLE_W-1:0]    alpha,
    input logic                               end_of_line,
    input logic                               end_of_frame
);

    import yuvrgb_pkg::*;

    // The pixel channel may only be held back when a finished result is itself held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (rgb_valid && rgb_stall))
        else $error("pixel channel stalled while the result channel was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && end_of_frame) |-> end_of_line)
        else $error("end of frame without end of line");

    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> (alpha == ALPHA_OPAQUE))
        else $error("alpha is not opaque");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(red) && $stable(green)
                                      && $stable(blue) && $stable(end_of_line)
                                      && $stable(end_of_frame)))
        else $error("stalled result transfer changed");

endmodule

bind yuv420_to_rgb32_converter yuvrgb_checker u_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import yuvrgb_pkg::*;

    localparam int MAX_WIDTH = 2048;
    localparam int CHROMA_SLOTS = MAX_WIDTH / 2;
    localparam int FRAC_BITS = 16;

    localparam longint COEF_CR_RED   = ((64'sd1402 << FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam longint COEF_CB_GREEN = ((64'sd34414 << FRAC_BITS) + 64'sd50000) / 64'sd100000;
    localparam longint COEF_CR_GREEN = ((64'sd71414 << FRAC_BITS) + 64'sd50000) / 64'sd100000;
    localparam longint COEF_CB_BLUE  = ((64'sd1772 << FRAC_BITS) + 64'sd500) / 64'sd1000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] alpha;
        logic                end_of_line;
        logic                end_of_frame;
    } rgb_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_stall;
    logic [SAMPLE_W-1:0]    y_sample = '0;
    logic [SAMPLE_W-1:0]    u_sample = '0;
    logic [SAMPLE_W-1:0]    v_sample = '0;
    logic                   start_of_frame = 1'b0;
    logic                   rgb_valid;
    logic                   rgb_stall = 1'b0;
    logic [SAMPLE_W-1:0]    red;
    logic [SAMPLE_W-1:0]    green;
    logic [SAMPLE_W-1:0]    blue;
    logic [SAMPLE_W-1:0]    alpha;
    logic                   end_of_line;
    logic                   end_of_frame;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned error_count = 0;

    logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RESET);
    int unsigned           column_pos = 0;
    int unsigned           row_pos = 0;
    logic [CHROMA_W-1:0]   held_chroma = '0;
    logic [CHROMA_W-1:0]   chroma_store [CHROMA_SLOTS];
    bit                    chroma_written [CHROMA_SLOTS];
    rgb_result_t           rgb_expected [$];

    yuv420_to_rgb32_converter dut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rgb_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return 32'(height_reg);
    endfunction

    function automatic void locate_pixel(input logic sof, output int unsigned col,
                                         output int unsigned row);
        col = sof ? 0 : column_pos;
        row = sof ? 0 : row_pos;
        if (col >= active_width())
        begin
            col = 0;
            row++;
        end
        if (row >= active_height())
            row = 0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_component(input longint acc);
        if (acc < 0)
            return '0;
        acc = acc >>> FRAC_BITS;
        return (acc > 255) ? COMPONENT_MAX : acc[SAMPLE_W-1:0];
    endfunction

    task automatic predict_pixel(input logic [SAMPLE_W-1:0] y, u, v, input logic sof);
        int unsigned col;
        int unsigned row;
        int unsigned slot;
        int unsigned w;
        int unsigned h;
        chroma_src_t src;
        longint luma;
        longint cb;
        longint cr;
        rgb_result_t res;
        w = active_width();
        h = active_height();
        locate_pixel(sof, col, row);
        slot = col >> 1;
        if (row[0] == 1'b1)
            src = CHROMA_LINE;
        else if (col[0] == 1'b1)
            src = CHROMA_HOLD;
        else
            src = CHROMA_NEW;
        case (src)
            CHROMA_NEW:
            begin
                held_chroma = {u, v};
                chroma_store[slot] = held_chroma;
                chroma_written[slot] = 1'b1;
            end
            CHROMA_LINE:
                held_chroma = chroma_store[slot];
            default:
                ;
        endcase
        cb = longint'(held_chroma[CHROMA_W-1:SAMPLE_W]) - CHROMA_BIAS;
        cr = longint'(held_chroma[SAMPLE_W-1:0]) - CHROMA_BIAS;
        luma = longint'(y) << FRAC_BITS;
        res.red = to_component(luma + COEF_CR_RED * cr);
        res.green = to_component(luma - COEF_CB_GREEN * cb - COEF_CR_GREEN * cr);
        res.blue = to_component(luma + COEF_CB_BLUE * cb);
        res.alpha = ALPHA_OPAQUE;
        res.end_of_line = (col == w - 1);
        res.end_of_frame = res.end_of_line && (row == h - 1);
        rgb_expected.push_back(res);
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        column_pos = col;
        row_pos = row;
    endtask

    always @(posedge clk)
    begin : check_rgb
        rgb_result_t want;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (rgb_expected.size() == 0)
                flag_error("result transfer with no pixel outstanding");
            else
            begin
                want = rgb_expected.pop_front();
                compare_field("red", red, want.red);
                compare_field("green", green, want.green);
                compare_field("blue", blue, want.blue);
                compare_field("alpha", alpha, want.alpha);
                compare_field("end_of_line", SAMPLE_W'(end_of_line),
                              SAMPLE_W'(want.end_of_line));
                compare_field("end_of_frame", SAMPLE_W'(end_of_frame),
                              SAMPLE_W'(want.end_of_frame));
            end
        end
    end

    // A pixel that would read a line store entry never written restarts the frame instead.
    task automatic send_pixel(input logic [SAMPLE_W-1:0] y, u, v, input logic sof);
        int unsigned col;
        int unsigned row;
        logic restart;
        restart = sof;
        locate_pixel(1'b0, col, row);
        if (row[0] && !chroma_written[col >> 1])
            restart = 1'b1;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        y_sample <= y;
        u_sample <= u;
        v_sample <= v;
        start_of_frame <= restart;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        predict_pixel(y, u, v, restart);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COMPONENT_MAX;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_run(input int unsigned count, input logic restart);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(random_sample(), random_sample(), random_sample(), restart && i == 0);
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (rgb_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LINE_WIDTH)
            width_reg = data;
        else if (idx == CFG_FRAME_HEIGHT)
            height_reg = data;
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        drain_results();
        write_config(CFG_LINE_WIDTH, w);
        write_config(CFG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_and_clamping();
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        set_frame(12'd4, 12'd2);
        send_pixel(8'd16, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd235, random_sample(), random_sample(), 1'b0);
        send_pixel(8'd128, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd200, random_sample(), random_sample(), 1'b0);
        send_run(4, 1'b0);
        send_pixel(8'd50, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd60, 8'd1, 8'd254, 1'b0);
        send_pixel(8'd70, 8'd254, 8'd1, 1'b1);
        send_run(3, 1'b0);
    endtask

    task automatic test_counter_wrap();
        set_frame(12'd16, 12'd8);
        send_run(21, 1'b1);
        set_frame(12'd3, 12'd8);
        send_run(7, 1'b0);
        set_frame(12'd3, 12'd2);
        send_run(8, 1'b0);
        set_frame(12'd0, 12'd0);
        send_run(5, 1'b0);
        set_frame(12'd1, 12'd3);
        send_run(7, 1'b1);
        set_frame(12'd2, 12'd1);
        send_run(5, 1'b0);
    endtask

    task automatic test_widest_line();
        set_frame(12'd4095, 12'd2);
        send_run(150, 1'b1);
        set_frame(12'd2048, 12'd1);
        send_run(6, 1'b1);
    endtask

    task automatic test_tallest_frame();
        set_frame(12'd0, 12'd4095);
        send_run(120, 1'b1);
        set_frame(12'd1, 12'd2048);
        send_run(6, 1'b1);
    endtask

    task automatic test_random_raster(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = CFG_DATA_W'($urandom_range(2048, 4095));
                default: w = CFG_DATA_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0: h = '0;
                1: h = CFG_DATA_W'($urandom_range(2048, 4095));
                default: h = CFG_DATA_W'($urandom_range(1, 6));
            endcase
            set_frame(w, h);
            burst = $urandom_range(1, 80);
            if (burst > count - sent)
                burst = count - sent;
            for (int unsigned i = 0; i < burst; i++)
            begin
                send_pixel(random_sample(), random_sample(), random_sample(),
                           (i == 0 && $urandom_range(0, 9) != 0) ||
                           $urandom_range(0, 39) == 0);
            end
            sent += burst;
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle_pct = 21;
        receiver_stall_pct = 86;
        test_reset_and_clamping();
        test_random_raster(250);
        sender_idle_pct = 86;
        receiver_stall_pct = 21;
        test_counter_wrap();
        test_random_raster(250);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_widest_line();
        test_tallest_frame();
        test_random_raster(150);
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
